// ===== src/efe_pkg.sv =====
// Shared types, byte codes and escape helpers for the escaped frame encoder.
package efe_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h02;
  localparam logic [7:0] ESC_ESC   = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // One classified request, handed from the front to the back.
  typedef struct packed {
    logic       open;   // frame not yet open: send opening flag first
    logic [7:0] data;
    logic       last;
    logic [7:0] csum;   // running checksum including data
  } job_t;

  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = b inside {FLAG_BYTE, ESC_BYTE};
  endfunction

  function automatic logic [7:0] escape_code(input logic [7:0] b);
    escape_code = (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
  endfunction

endpackage

// ===== src/escaped_frame_encoder_xor.sv =====
// Top level of the escaped frame encoder with XOR checksum.
//   channel  | handshake     | fields
//   input    | push / full   | data_byte[7:0], msg_end
//   result   | pop / empty   | out_byte[7:0], run_last, frame_end
// Each input byte yields 1 to 6 result bytes; the back-end sequencer sends one
// result byte per cycle while no unpopped result stalls the output register.
// The front takes a new byte every cycle until the QDEPTH-entry job queue fills.
// With everything idle, an accepted byte passes through the job queue and the
// output register before its first result is on the ports. Reset (rst) empties
// the queue and the output register and closes any open frame.
module escaped_frame_encoder_xor import efe_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       msg_end,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_end,
  output logic       empty,
  input  logic       pop
);

  logic q_full;
  logic q_push;
  job_t q_wr_job;
  job_t q_rd_job;
  logic q_valid;
  logic q_pop;

  efe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .msg_end   (msg_end),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wr_job)
  );

  efe_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_rd_job),
    .valid  (q_valid)
  );

  efe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_rd_job),
    .job_done  (q_pop),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .frame_end (frame_end),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== src/efe_front.sv =====
// Front end: accepts input bytes, tracks frame state and checksum, builds jobs.
module efe_front import efe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       msg_end,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [7:0] running_xor;
  logic       inside_frame;
  logic [7:0] xor_next;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign xor_next = (inside_frame ? running_xor : ZERO_BYTE) ^ data_byte;

  always_comb begin
    q_job.open = !inside_frame;
    q_job.data = data_byte;
    q_job.last = msg_end;
    q_job.csum = xor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor  <= ZERO_BYTE;
      inside_frame <= 1'b0;
    end else if (q_push) begin
      if (msg_end) begin
        running_xor  <= ZERO_BYTE;
        inside_frame <= 1'b0;
      end else begin
        running_xor  <= xor_next;
        inside_frame <= 1'b1;
      end
    end
  end

endmodule

// ===== src/efe_queue.sv =====
// Short job queue between the front and the back.
module efe_queue import efe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == DEPTH_CNT);
  assign valid  = (count != '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && valid;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/efe_back.sv =====
// Back end: expands one job into framed, escaped bytes, one per cycle unless stalled.
module efe_back import efe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_done,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_end,
  output logic       empty,
  input  logic       pop
);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_OPEN  = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_DATA2 = 3'd3;
  localparam logic [2:0] PH_CSUM  = 3'd4;
  localparam logic [2:0] PH_CSUM2 = 3'd5;
  localparam logic [2:0] PH_CLOSE = 3'd6;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [2:0] cur;
  logic       ovalid;
  logic       step;
  logic [7:0] byte_next;
  logic       last_next;
  logic       end_next;

  assign empty = !ovalid;
  assign step  = job_valid && (!ovalid || pop);
  assign cur   = (phase == PH_FIRST) ? (job.open ? PH_OPEN : PH_DATA) : phase;

  always_comb begin
    byte_next  = FLAG_BYTE;
    last_next  = 1'b0;
    end_next   = 1'b0;
    phase_next = cur;
    job_done   = 1'b0;
    case (cur)
      PH_OPEN: begin
        byte_next  = FLAG_BYTE;
        phase_next = PH_DATA;
      end
      PH_DATA, PH_DATA2: begin
        if (cur == PH_DATA && needs_escape(job.data)) begin
          byte_next  = ESC_BYTE;
          phase_next = PH_DATA2;
        end else begin
          byte_next = (cur == PH_DATA2) ? escape_code(job.data) : job.data;
          if (job.last) begin
            phase_next = PH_CSUM;
          end else begin
            last_next  = 1'b1;
            job_done   = 1'b1;
            phase_next = PH_FIRST;
          end
        end
      end
      PH_CSUM, PH_CSUM2: begin
        if (cur == PH_CSUM && needs_escape(job.csum)) begin
          byte_next  = ESC_BYTE;
          phase_next = PH_CSUM2;
        end else begin
          byte_next  = (cur == PH_CSUM2) ? escape_code(job.csum) : job.csum;
          phase_next = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        byte_next  = FLAG_BYTE;
        last_next  = 1'b1;
        end_next   = 1'b1;
        job_done   = 1'b1;
        phase_next = PH_FIRST;
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase
    if (!step) begin
      job_done   = 1'b0;
      phase_next = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_FIRST;
      ovalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (step) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte  <= byte_next;
      run_last  <= last_next;
      frame_end <= end_next;
    end
  end

endmodule

// ===== src/efe_checker.sv =====
// Port-level checker for the escaped frame encoder, bound to the top level.
module efe_checker import efe_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       frame_end,
  input logic       empty,
  input logic       pop
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue state not cleared by reset");

  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> (out_byte == FLAG_BYTE) && run_last)
    else $error("closing flag malformed");

  a_open_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_byte == FLAG_BYTE && !frame_end) |-> !run_last)
    else $error("opening flag marked as last of request");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(out_byte) && $stable(run_last))
    else $error("stalled result changed");

endmodule

bind escaped_frame_encoder_xor efe_checker u_efe_checker (.*);
